// ----- design/pidaw_pkg.sv -----
// Shared types, constants and helpers of the anti-windup PID controller.
package pidaw_pkg;

  // Default fraction bits of the Q format
  localparam int FRACTION_BITS_DEF = 16;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Shared multiplier operand width: 32-bit signed or 31-bit unsigned, as signed
  localparam int OPW = 33;

  // Register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_DT   = 3'd3,
    REG_RDT  = 3'd4,
    REG_IMIN = 3'd5,
    REG_IMAX = 3'd6,
    REG_LIM  = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic signed [31:0] KP_RST   = 32'sd65536;
  localparam logic signed [31:0] KI_RST   = 32'sd0;
  localparam logic signed [31:0] KD_RST   = 32'sd0;
  localparam logic        [30:0] DT_RST   = 31'd655;
  localparam logic        [30:0] RDT_RST  = 31'd6553600;
  localparam logic signed [31:0] IMIN_RST = -32'sd6553600;
  localparam logic signed [31:0] IMAX_RST = 32'sd6553600;
  localparam logic        [30:0] LIM_RST  = 31'd6553600;

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic        [30:0] dt;
    logic        [30:0] rdt;
    logic signed [31:0] imin;
    logic signed [31:0] imax;
    logic        [30:0] lim;
  } pidaw_cfg_t;

  localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

  // Saturate a widened sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/pid_controller_anti_windup.sv -----
// Top level of the PID controller with conditional-integration anti-windup.
//
//  channel   dir  handshake                 payload
//  in_*      in   in_tvalid / in_tready     tdata target, measurement; tuser cmd
//  out_*     out  out_tvalid / out_tready   tdata drive; tuser at_limit
//  cfg_*     in   psel, penable, pready     APB writes and reads, registers at 4*i
//
// A compute item passes through MDT, CAND, KP, KI, KD, SUM and DONE on its way
// to the output register: five products pass one after another through the shared multiplier.
// A clear item goes straight to DONE. in_tready is high only while the sequencer is idle,
// so a new item is taken only once the last one has left DONE.
// A result waits in the output register while the next item is taken; the
// sequencer holds its last step while that register is still full.
// Reset is synchronous and active low; it restores register defaults and
// zeroes integral and previous error.
module pid_controller_anti_windup
  import pidaw_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,    // [31:0] target, [63:32] measurement
  input  logic [0:0]        in_tuser,    // [0] cmd
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,   // [31:0] drive
  output logic [0:0]        out_tuser,   // [0] at_limit
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MDT  = 8'b0000_0010,
    ST_CAND = 8'b0000_0100,
    ST_KP   = 8'b0000_1000,
    ST_KI   = 8'b0001_0000,
    ST_KD   = 8'b0010_0000,
    ST_SUM  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  pidaw_cfg_t cfg;

  state_t             state_r, state_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [31:0] dlt_r, dlt_nxt;
  logic signed [31:0] cand_r, cand_nxt;
  logic signed [31:0] der_r, der_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic               clr_r, clr_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic signed [31:0] drive_r, drive_nxt;
  logic               hit_r, hit_nxt;

  logic signed [OPW-1:0] op_a, op_b;
  logic signed [31:0]    q;
  logic                  in_xfer;
  logic                  out_free;
  logic signed [31:0]    tgt, meas;
  logic signed [31:0]    isum;
  logic signed [31:0]    lim_pos, lim_neg;
  logic signed [31:0]    dsat, dclamp;
  logic                  dhit;

  pidaw_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  pidaw_mul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk (clk),
    .op_a(op_a),
    .op_b(op_b),
    .q   (q)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = drive_r;
  assign out_tuser  = hit_r;
  assign tgt        = in_tdata[31:0];
  assign meas       = in_tdata[63:32];

  // Select the multiplier operands for the step being issued
  always_comb begin
    case (state_r)
      ST_MDT: begin
        op_a = {err_r[31], err_r};
        op_b = {2'b00, cfg.dt};
      end
      ST_CAND: begin
        op_a = {dlt_r[31], dlt_r};
        op_b = {2'b00, cfg.rdt};
      end
      ST_KP: begin
        op_a = {cfg.kp[31], cfg.kp};
        op_b = {err_r[31], err_r};
      end
      ST_KI: begin
        op_a = {cfg.ki[31], cfg.ki};
        op_b = {cand_r[31], cand_r};
      end
      ST_KD: begin
        op_a = {cfg.kd[31], cfg.kd};
        op_b = {der_r[31], der_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Integral update, saturated before the bound clamp
  assign isum = sat32({{2{integ_r[31]}}, integ_r} + {{2{q[31]}}, q});

  // Drive clamp to the symmetric limit
  assign lim_pos = {1'b0, cfg.lim};
  assign lim_neg = -lim_pos;
  assign dsat    = sat32(acc_r);
  always_comb begin
    if (dsat > lim_pos) begin
      dclamp = lim_pos;
    end else if (dsat < lim_neg) begin
      dclamp = lim_neg;
    end else begin
      dclamp = dsat;
    end
  end
  assign dhit = (dclamp == lim_pos) || (dclamp == lim_neg);

  // Sequence one item through the shared multiplier
  always_comb begin
    state_nxt      = state_r;
    err_nxt        = err_r;
    dlt_nxt        = dlt_r;
    cand_nxt       = cand_r;
    der_nxt        = der_r;
    integ_nxt      = integ_r;
    prev_nxt       = prev_r;
    acc_nxt        = acc_r;
    clr_nxt        = clr_r;
    drive_nxt      = drive_r;
    hit_nxt        = hit_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          err_nxt = sat32({{2{tgt[31]}}, tgt} - {{2{meas[31]}}, meas});
          clr_nxt = in_tuser[0];
          if (in_tuser[0]) begin
            acc_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MDT;
          end
        end
      end
      ST_MDT: begin
        dlt_nxt   = sat32({{2{err_r[31]}}, err_r} - {{2{prev_r[31]}}, prev_r});
        state_nxt = ST_CAND;
      end
      ST_CAND: begin
        if (isum > cfg.imax) begin
          cand_nxt = cfg.imax;
        end else if (isum < cfg.imin) begin
          cand_nxt = cfg.imin;
        end else begin
          cand_nxt = isum;
        end
        state_nxt = ST_KP;
      end
      ST_KP: begin
        der_nxt   = q;
        state_nxt = ST_KI;
      end
      ST_KI: begin
        acc_nxt   = {{2{q[31]}}, q};
        state_nxt = ST_KD;
      end
      ST_KD: begin
        acc_nxt   = acc_r + {{2{q[31]}}, q};
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        acc_nxt   = acc_r + {{2{q[31]}}, q};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          drive_nxt      = dclamp;
          hit_nxt        = dhit;
          out_tvalid_nxt = 1'b1;
          if (clr_r) begin
            integ_nxt = '0;
            prev_nxt  = '0;
          end else begin
            prev_nxt = err_r;
            if (!dhit) begin
              integ_nxt = cand_r;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      integ_r      <= '0;
      prev_r       <= '0;
      clr_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      integ_r      <= integ_nxt;
      prev_r       <= prev_nxt;
      clr_r        <= clr_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    err_r   <= err_nxt;
    dlt_r   <= dlt_nxt;
    cand_r  <= cand_nxt;
    der_r   <= der_nxt;
    acc_r   <= acc_nxt;
    drive_r <= drive_nxt;
    hit_r   <= hit_nxt;
  end

  // A transfer in starts work, so the next item waits
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while previous item in flight");

  // A clear item skips the multiplier sequence
  a_clear_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser[0]) |=> (state_r == ST_DONE))
    else $error("clear item did not go straight to result");

  // A compute item starts with the first product
  a_compute_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tuser[0]) |=> (state_r == ST_MDT))
    else $error("compute item did not start the product sequence");

  // Finishing a clear zeroes the stored state
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && clr_r && out_free) |=> (integ_r == '0 && prev_r == '0))
    else $error("clear item left integral or previous error");

endmodule

// ----- design/pidaw_regs.sv -----
// APB-style configuration register file of the PID controller.
module pidaw_regs
  import pidaw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output pidaw_cfg_t        cfg
);

  pidaw_cfg_t cfg_r;
  pidaw_cfg_t cfg_nxt;
  cfg_idx_t   idx;
  logic       wr_en;

  assign idx        = cfg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Decode the write transfer
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_KP:   cfg_nxt.kp   = cfg_pwdata;
        REG_KI:   cfg_nxt.ki   = cfg_pwdata;
        REG_KD:   cfg_nxt.kd   = cfg_pwdata;
        REG_DT:   cfg_nxt.dt   = cfg_pwdata[30:0];
        REG_RDT:  cfg_nxt.rdt  = cfg_pwdata[30:0];
        REG_IMIN: cfg_nxt.imin = cfg_pwdata;
        REG_IMAX: cfg_nxt.imax = cfg_pwdata;
        REG_LIM:  cfg_nxt.lim  = cfg_pwdata[30:0];
        default:  cfg_nxt      = cfg_r;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_KP:   cfg_prdata = cfg_r.kp;
      REG_KI:   cfg_prdata = cfg_r.ki;
      REG_KD:   cfg_prdata = cfg_r.kd;
      REG_DT:   cfg_prdata = {1'b0, cfg_r.dt};
      REG_RDT:  cfg_prdata = {1'b0, cfg_r.rdt};
      REG_IMIN: cfg_prdata = cfg_r.imin;
      REG_IMAX: cfg_prdata = cfg_r.imax;
      REG_LIM:  cfg_prdata = {1'b0, cfg_r.lim};
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp   <= KP_RST;
      cfg_r.ki   <= KI_RST;
      cfg_r.kd   <= KD_RST;
      cfg_r.dt   <= DT_RST;
      cfg_r.rdt  <= RDT_RST;
      cfg_r.imin <= IMIN_RST;
      cfg_r.imax <= IMAX_RST;
      cfg_r.lim  <= LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/pidaw_mul.sv -----
// Shared fixed-point multiplier: registered product, floor shift, 32-bit saturation.
module pidaw_mul
  import pidaw_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic signed [OPW-1:0] op_a,
  input  logic signed [OPW-1:0] op_b,
  output logic signed [31:0]    q
);

  localparam int PW = 2 * OPW;

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] shifted;
  logic [PW-32:0]       upper;

  assign prod_nxt = op_a * op_b;

  // Arithmetic shift rounds toward minus infinity
  assign shifted = prod_r >>> FRACTION_BITS;
  assign upper   = shifted[PW-1:31];

  // Clip when the high bits are not all copies of the sign
  always_comb begin
    if ((&upper) || !(|upper)) begin
      q = shifted[31:0];
    end else if (shifted[PW-1]) begin
      q = 32'sh8000_0000;
    end else begin
      q = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- bench/pid_controller_anti_windup_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the anti-windup PID controller: directed and random steps.
module pid_controller_anti_windup_tb;
  import pidaw_pkg::*;

  localparam int   FRAC      = FRACTION_BITS_DEF;
  localparam int   SHOW_MAX  = 40;
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [63:0]       in_tdata;    // [31:0] target, [63:32] measurement
  logic [0:0]        in_tuser;    // [0] cmd
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;   // [31:0] drive
  logic [0:0]        out_tuser;   // [0] at_limit
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // No idling on either side once this is set
  logic        quiet_tail;
  int unsigned in_idle_pct;

  // Mirror of the controller: register copy, integral and last error
  class drive_scoreboard;
    typedef struct {
      logic [31:0] drive;
      logic        at_limit;
    } drive_t;

    drive_t      due_drives[$];
    longint      kp, ki, kd, dt, rdt, imin, imax, lim;
    longint      integ, prev_err;
    int unsigned errors;

    function new();
      kp       = 65536;
      ki       = 0;
      kd       = 0;
      dt       = 655;
      rdt      = 6553600;
      imin     = -6553600;
      imax     = 6553600;
      lim      = 6553600;
      integ    = 0;
      prev_err = 0;
      errors   = 0;
    endfunction

    function longint clip_s32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Full-precision product, floor shift, then saturate
    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clip_s32(p >>> FRAC);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      longint sv, uv;
      sv = longint'($signed(val));
      uv = longint'({1'b0, val[30:0]});
      case (idx)
        REG_KP:   kp   = sv;
        REG_KI:   ki   = sv;
        REG_KD:   kd   = sv;
        REG_DT:   dt   = uv;
        REG_RDT:  rdt  = uv;
        REG_IMIN: imin = sv;
        REG_IMAX: imax = sv;
        REG_LIM:  lim  = uv;
        default: ;
      endcase
    endfunction

    // Advance the mirrored state by one accepted item and queue its drive
    function void note_step(logic cmd, logic [31:0] tgt, logic [31:0] meas);
      longint err, cand, deriv, drv;
      drive_t d;
      if (cmd == CMD_CLEAR) begin
        integ    = 0;
        prev_err = 0;
        drv      = 0;
      end else begin
        err  = clip_s32(longint'($signed(tgt)) - longint'($signed(meas)));
        cand = clip_s32(integ + qmul(err, dt));
        // upper bound is tested first, so inverted bounds favor it
        if (cand > imax) begin
          cand = imax;
        end else if (cand < imin) begin
          cand = imin;
        end
        deriv = qmul(clip_s32(err - prev_err), rdt);
        drv   = clip_s32(qmul(kp, err) + qmul(ki, cand) + qmul(kd, deriv));
        if (drv > lim) begin
          drv = lim;
        end else if (drv < -lim) begin
          drv = -lim;
        end
        // hold the integral while the drive sits on a limit
        if (drv != lim && drv != -lim) begin
          integ = cand;
        end
        prev_err = err;
      end
      d.drive    = drv[31:0];
      d.at_limit = (drv == lim) || (drv == -lim);
      due_drives.push_back(d);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= SHOW_MAX) begin
        $display("%0t mismatch: %s", $time, msg);
      end
    endtask

    task check_drive(logic [31:0] drive, logic flag);
      drive_t d;
      if (due_drives.size() == 0) begin
        report($sformatf("result with nothing pending, drive %h", drive));
      end else begin
        d = due_drives.pop_front();
        if (drive !== d.drive) begin
          report($sformatf("drive %h, predicted %h", drive, d.drive));
        end
        if (flag !== d.at_limit) begin
          report($sformatf("at_limit %b, predicted %b (drive %h)", flag, d.at_limit, d.drive));
        end
      end
    endtask
  endclass

  drive_scoreboard sb;

  pid_controller_anti_windup uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #(1_000_000);
    $display("pid_controller_anti_windup_tb: done, errors");
    $finish;
  end

  // Offer one item and hold it until the transfer
  task automatic send_item(logic cmd, logic [31:0] tgt, logic [31:0] meas);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {meas, tgt};
    do @(posedge clk); while (!in_tready);
    sb.note_step(cmd, tgt, meas);
  endtask

  // Drop valid for a short random burst now and then
  task automatic maybe_pause();
    int unsigned n;
    if (!quiet_tail && $urandom_range(0, 99) < in_idle_pct) begin
      n = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every pending drive
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_drives.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, access cycle until pready, then back to idle
  task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] dt, logic [31:0] rdt, logic [31:0] imin,
                           logic [31:0] imax, logic [31:0] lim);
    cfg_write(REG_KP, kp);
    cfg_write(REG_KI, ki);
    cfg_write(REG_KD, kd);
    cfg_write(REG_DT, dt);
    cfg_write(REG_RDT, rdt);
    cfg_write(REG_IMIN, imin);
    cfg_write(REG_IMAX, imax);
    cfg_write(REG_LIM, lim);
  endtask

  // Gains: mostly within +-4.0, sometimes extreme
  function automatic logic [31:0] pick_gain();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    case (r)
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = 32'h0;
      3:       v = $urandom;
      default: v = $urandom_range(0, 262144);
    endcase
    if (r > 3 && $urandom_range(0, 2) == 0) begin
      v = -v;
    end
    return v;
  endfunction

  // Unsigned 31-bit fields; bit 31 is random and must be dropped by the block
  function automatic logic [31:0] pick_u31(int unsigned typ);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h0;
      2:       v = $urandom;
      default: v = $urandom_range(0, typ);
    endcase
    v[31] = $urandom_range(0, 1);
    return v;
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 9))
      0:       return int'(32'h7FFF_FFFF);
      1:       return int'(32'h8000_0000);
      2:       return int'($urandom);
      default: return int'($urandom_range(0, 6553600)) - 3276800;
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] lo, hi;
    case ($urandom_range(0, 7))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        // inverted bounds
        lo = $urandom_range(65536, 655360);
        hi = -$urandom_range(0, 655360);
      end
      default: begin
        lo = -$urandom_range(0, 1310720);
        hi = $urandom_range(0, 1310720);
      end
    endcase
    write_all(pick_gain(), pick_gain(), pick_gain(), pick_u31(6554), pick_u31(6553600),
              lo, hi, pick_u31(13107200));
  endtask

  // Runs of a held target with the measurement closing in, plus clears and noise
  task automatic run_phase(int unsigned n);
    int unsigned k, run_left;
    int tgt, meas;
    run_left = 0;
    tgt      = 0;
    meas     = 0;
    for (k = 0; k < n; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(5, 40);
        tgt      = pick_level();
        meas     = pick_level();
      end
      run_left--;
      maybe_pause();
      case ($urandom_range(0, 19))
        0:    send_item(CMD_CLEAR, $urandom, $urandom);
        1, 2: send_item(CMD_STEP, $urandom, $urandom);
        default: begin
          meas = meas + (tgt - meas) / 4 + int'($urandom_range(0, 2000)) - 1000;
          send_item(CMD_STEP, tgt, meas);
        end
      endcase
    end
  endtask

  // Result side: random stalls, two long hold-offs, none in the tail
  initial begin : result_sink
    int unsigned stall_left, window, stall_pct, got;
    stall_left = 0;
    window     = 0;
    stall_pct  = 0;
    got        = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_drive(out_tdata, out_tuser[0]);
        got++;
        if (got == 300 || got == 900) begin
          stall_left = 120;
        end
      end
      if (window == 0) begin
        window = 64;
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      window--;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned p;
    sb          = new();
    in_idle_pct = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    quiet_tail  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unit proportional gain, drive clamps at 100.0
    send_item(CMD_STEP, 32'h0, 32'h0);
    send_item(CMD_STEP, 32'd65536, 32'h0);
    send_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_STEP, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'h1234_5678);
    send_item(CMD_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // half gains expose floor rounding; integral clamps at +-10.0
    drain();
    write_all(32'h0000_8000, 32'd65536, 32'hFFFF_8000, 32'd65536, 32'd65536,
              -32'd655360, 32'd655360, 32'hFFFF_FFFF);
    send_item(CMD_STEP, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_STEP, 32'd3, 32'h0);
    send_item(CMD_STEP, 32'd1310720, 32'h0);
    send_item(CMD_STEP, -32'd1310720, 32'h0);
    send_item(CMD_CLEAR, 32'h0, 32'h0);

    // every register at an extreme: products and sums saturate
    drain();
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_STEP, 32'h1, 32'h0);
    send_item(CMD_STEP, 32'h0, 32'h0);

    // inverted integral bounds: min 5.0 above max -5.0
    drain();
    write_all(32'h0, 32'd65536, 32'h0, 32'd65536, 32'd65536,
              32'd327680, -32'd327680, 32'd3276800);
    send_item(CMD_STEP, 32'd131072, 32'h0);
    send_item(CMD_STEP, -32'd1310720, 32'h0);
    send_item(CMD_STEP, 32'd1310720, 32'h0);

    // zero output limit: drive pinned at 0 and always at a limit
    drain();
    cfg_write(REG_LIM, 32'h0);
    send_item(CMD_STEP, 32'd65536, 32'h0);
    send_item(CMD_STEP, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_CLEAR, 32'h0, 32'h0);

    // random phases, each under its own settings
    for (p = 0; p < 9; p++) begin
      drain();
      random_config();
      case ($urandom_range(0, 2))
        0:       in_idle_pct = 0;
        1:       in_idle_pct = 25;
        default: in_idle_pct = 50;
      endcase
      if (p == 8) begin
        quiet_tail <= 1'b1;
      end
      if (p == 3) begin
        // pause mid-phase until the output side has caught up
        run_phase(85);
        drain();
        run_phase(85);
      end else begin
        run_phase(170);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due_drives.size() == 0) begin
      $display("pid_controller_anti_windup_tb: done, clean");
    end else begin
      $display("pid_controller_anti_windup_tb: done, errors");
    end
    $finish;
  end

endmodule
